FILE: hw/rtl/tes_pkg.sv
`timescale 1ns / 1ps

package tes_pkg;

    // Field widths
    localparam int CoordBits = 10;
    localparam int VertW     = 30;
    localparam int CondW     = 32;
    localparam int StepW     = 32;
    localparam int OutW      = 48;
    localparam int NEnt      = 10;

    // Internal widths derived from the field widths
    localparam int EdgeW   = CoordBits + 1;
    localparam int GradW   = 2 * CoordBits + 4;
    localparam int DetW    = 3 * CoordBits + 6;
    localparam int DotW    = 2 * GradW + 2;
    localparam int MagHalf = DotW / 2;
    localparam int CsW     = CondW + StepW;
    localparam int CsHalf  = CsW / 2;
    localparam int PartW   = MagHalf + CsHalf;
    localparam int AccW    = PartW + CsHalf + 1;
    localparam int NumW    = DotW + CsW + 1;
    localparam int DenW    = DetW + 11;
    localparam int QBits   = OutW - 1;
    localparam int RemW    = DenW + QBits;

    localparam logic [StepW-1:0] StepReset = StepW'(65536);
    localparam logic [OutW-1:0]  PosMax    = {1'b0, {(OutW-1){1'b1}}};
    localparam logic [OutW-1:0]  NegMin    = {1'b1, {(OutW-1){1'b0}}};

    // Row and column of each upper-triangle entry
    localparam int EntI [NEnt] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
    localparam int EntJ [NEnt] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};

    // Cyclic neighbors for cross products
    localparam int Nx [3] = '{1, 2, 0};
    localparam int Nn [3] = '{2, 0, 1};

    typedef logic signed [EdgeW-1:0] t_edge;
    typedef logic signed [GradW-1:0] t_grad;
    typedef logic signed [DetW-1:0]  t_det;
    typedef logic signed [DotW-1:0]  t_dot;
    typedef logic [DotW-1:0]         t_mag;
    typedef logic [CsW-1:0]          t_cs;
    typedef logic [PartW-1:0]        t_part;
    typedef logic [AccW-1:0]         t_acc;
    typedef logic [NumW-1:0]         t_num;
    typedef logic [DenW-1:0]         t_den;
    typedef logic [RemW-1:0]         t_rem;
    typedef logic [QBits-1:0]        t_quo;
    typedef logic [VertW-1:0]        t_vert;

    typedef t_dot t_prod3 [3];
    typedef t_prod3 t_prod_arr [NEnt];
    typedef t_num t_num_arr [NEnt];
    typedef t_quo t_quo_arr [NEnt];
    typedef logic [NEnt-1:0] t_flags;
    typedef logic [OutW-1:0] t_out_arr [NEnt];

    // Per-item flags that ride along with the quotients
    typedef struct packed {
        logic   deg;
        t_flags neg;
        t_flags ovf;
    } t_div_flags;

endpackage

FILE: hw/rtl/tes_geom.sv
`timescale 1ns / 1ps

module tes_geom (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  tes_pkg::t_vert     i_vert [4],
    input  logic [31:0]        i_cond,
    input  logic [31:0]        i_step,
    output logic               o_valid,
    output tes_pkg::t_prod_arr o_prod,
    output tes_pkg::t_det      o_det,
    output tes_pkg::t_cs       o_cs
);
    import tes_pkg::*;

    logic  [3:0] r_v;
    t_edge r_e  [3][3];
    t_edge r_e1 [3];
    t_grad r_gc [3][3];
    t_grad r_g  [4][3];
    t_det  r_dp [3];
    t_cs   r_cs [4];
    t_dot  r_prod [NEnt][3];
    t_det  r_det;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // Edge vectors from the first vertex, conductivity times step
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < 3; n++) begin
                for (int c = 0; c < 3; c++) begin
                    r_e[n][c] <= $signed({1'b0, i_vert[n+1][c*CoordBits +: CoordBits]})
                               - $signed({1'b0, i_vert[0][c*CoordBits +: CoordBits]});
                end
            end
            r_cs[0] <= t_cs'(i_cond) * t_cs'(i_step);
        end
    end

    // Cross products g1 = e2 x e3, g2 = e3 x e1, g3 = e1 x e2
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int m = 0; m < 3; m++) begin
                for (int c = 0; c < 3; c++) begin
                    r_gc[m][c] <= t_grad'(r_e[Nx[m]][Nx[c]] * r_e[Nn[m]][Nn[c]]
                                        - r_e[Nx[m]][Nn[c]] * r_e[Nn[m]][Nx[c]]);
                end
            end
            r_e1    <= r_e[0];
            r_cs[1] <= r_cs[0];
        end
    end

    // Fourth gradient and determinant partials
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_g[1][c] <= r_gc[0][c];
                r_g[2][c] <= r_gc[1][c];
                r_g[3][c] <= r_gc[2][c];
                r_g[0][c] <= t_grad'(-(r_gc[0][c] + r_gc[1][c] + r_gc[2][c]));
                r_dp[c]   <= t_det'(r_e1[c] * r_gc[0][c]);
            end
            r_cs[2] <= r_cs[1];
        end
    end

    // Gradient component products and determinant sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < NEnt; n++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[n][c] <= t_dot'(r_g[EntI[n]][c] * r_g[EntJ[n]][c]);
                end
            end
            r_det   <= t_det'(r_dp[0] + r_dp[1] + r_dp[2]);
            r_cs[3] <= r_cs[2];
        end
    end

    always_comb begin
        for (int n = 0; n < NEnt; n++) begin
            for (int c = 0; c < 3; c++) begin
                o_prod[n][c] = r_prod[n][c];
            end
        end
    end

    assign o_valid = r_v[3];
    assign o_det   = r_det;
    assign o_cs    = r_cs[3];

endmodule

FILE: hw/rtl/tes_scale.sv
`timescale 1ns / 1ps

module tes_scale (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  tes_pkg::t_prod_arr i_prod,
    input  tes_pkg::t_det      i_det,
    input  tes_pkg::t_cs       i_cs,
    input  logic               i_step_zero,
    output logic               o_valid,
    output tes_pkg::t_num_arr  o_num,
    output tes_pkg::t_den      o_den,
    output tes_pkg::t_flags    o_neg,
    output logic               o_deg
);
    import tes_pkg::*;

    logic [3:0]    r_v;
    t_mag          r_mag [NEnt];
    t_flags        r_neg [4];
    logic          r_deg [4];
    t_den          r_den [4];
    t_cs           r_cs;
    t_part         r_pll [NEnt];
    t_part         r_plh [NEnt];
    t_part         r_phl [NEnt];
    t_part         r_phh [NEnt];
    t_acc          r_a   [NEnt];
    t_acc          r_b   [NEnt];
    t_num          r_num [NEnt];
    t_dot          w_dot [NEnt];
    logic [DetW-1:0] w_absdet;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // Dot products, magnitudes and result signs
    always_comb begin
        for (int n = 0; n < NEnt; n++) begin
            w_dot[n] = t_dot'(i_prod[n][0] + i_prod[n][1] + i_prod[n][2]);
        end
        w_absdet = i_det[DetW-1] ? DetW'(-i_det) : DetW'(i_det);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < NEnt; n++) begin
                r_mag[n]    <= w_dot[n][DotW-1] ? t_mag'(-w_dot[n]) : t_mag'(w_dot[n]);
                r_neg[0][n] <= w_dot[n][DotW-1] ^ i_det[DetW-1];
            end
            r_den[0] <= (t_den'(w_absdet) << 10) + (t_den'(w_absdet) << 9);
            r_deg[0] <= (i_det == '0) || i_step_zero;
            r_cs     <= i_cs;
        end
    end

    // Partial products of magnitude times conductivity-step
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < NEnt; n++) begin
                r_pll[n] <= t_part'(r_mag[n][MagHalf-1:0]) * t_part'(r_cs[CsHalf-1:0]);
                r_plh[n] <= t_part'(r_mag[n][MagHalf-1:0]) * t_part'(r_cs[CsW-1:CsHalf]);
                r_phl[n] <= t_part'(r_mag[n][DotW-1:MagHalf]) * t_part'(r_cs[CsHalf-1:0]);
                r_phh[n] <= t_part'(r_mag[n][DotW-1:MagHalf]) * t_part'(r_cs[CsW-1:CsHalf]);
            end
            r_neg[1] <= r_neg[0];
            r_deg[1] <= r_deg[0];
            r_den[1] <= r_den[0];
        end
    end

    // Combine partials by halves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < NEnt; n++) begin
                r_a[n] <= t_acc'(r_pll[n]) + (t_acc'(r_plh[n]) << CsHalf);
                r_b[n] <= t_acc'(r_phl[n]) + (t_acc'(r_phh[n]) << CsHalf);
            end
            r_neg[2] <= r_neg[1];
            r_deg[2] <= r_deg[1];
            r_den[2] <= r_den[1];
        end
    end

    // Full numerator plus half the denominator for rounding
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < NEnt; n++) begin
                r_num[n] <= t_num'(r_a[n]) + (t_num'(r_b[n]) << MagHalf)
                          + t_num'(r_den[2] >> 1);
            end
            r_neg[3] <= r_neg[2];
            r_deg[3] <= r_deg[2];
            r_den[3] <= r_den[2];
        end
    end

    assign o_valid = r_v[3];
    assign o_num   = r_num;
    assign o_den   = r_den[3];
    assign o_neg   = r_neg[3];
    assign o_deg   = r_deg[3];

endmodule

FILE: hw/rtl/tes_div.sv
`timescale 1ns / 1ps

module tes_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  tes_pkg::t_num_arr   i_num,
    input  tes_pkg::t_den       i_den,
    input  tes_pkg::t_flags     i_neg,
    input  logic                i_deg,
    output logic                o_valid,
    output tes_pkg::t_quo_arr   o_quo,
    output tes_pkg::t_div_flags o_flags
);
    import tes_pkg::*;

    logic [QBits:0] r_v;
    t_rem           r_rem [QBits+1][NEnt];
    t_quo           r_quo [QBits+1][NEnt];
    t_den           r_den [QBits+1];
    t_div_flags     r_fl  [QBits+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QBits-1:0], i_valid};
        end
    end

    // Catch quotients beyond the output range, load remainders
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < NEnt; n++) begin
                r_rem[0][n]   <= i_num[n][RemW-1:0];
                r_quo[0][n]   <= '0;
                r_fl[0].ovf[n] <= i_num[n] >= (t_num'(i_den) << QBits);
            end
            r_den[0]     <= i_den;
            r_fl[0].neg  <= i_neg;
            r_fl[0].deg  <= i_deg;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar s = 1; s <= QBits; s++) begin : g_stage
        localparam int K = QBits - s;
        t_rem w_dsh;
        assign w_dsh = t_rem'(r_den[s-1]) << K;

        for (genvar n = 0; n < NEnt; n++) begin : g_lane
            logic w_ge;
            assign w_ge = r_rem[s-1][n] >= w_dsh;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s][n] <= w_ge ? r_rem[s-1][n] - w_dsh : r_rem[s-1][n];
                    r_quo[s][n] <= r_quo[s-1][n] | (t_quo'(w_ge) << K);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s] <= r_den[s-1];
                r_fl[s]  <= r_fl[s-1];
            end
        end
    end

    assign o_valid = r_v[QBits];
    assign o_quo   = r_quo[QBits];
    assign o_flags = r_fl[QBits];

endmodule

FILE: hw/rtl/tet_element_stiffness.sv
`timescale 1ns / 1ps

// Tetrahedron element stiffness: takes one element per cycle (four packed grid
// vertices and a Q16.16 conductivity) and returns the ten upper-triangle
// entries of its conduction stiffness matrix as saturated signed Q24.24, each
// rounded to nearest with ties away from zero, plus a flag when the
// determinant or the step is zero (entries then read zero). The pipeline
// has four geometry stages, four scaling stages, a restoring divider of one
// range check and one quotient bit per stage for 47 bits, and the output
// register; the divider depth sets the latency. Throughput is one element
// per cycle; a stall at the output freezes the whole pipeline. Write
// step_size only while no request is in flight.
module tet_element_stiffness (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step_size_we,
    input  logic [31:0] i_step_size,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [29:0] i_vertex_a,
    input  logic [29:0] i_vertex_b,
    input  logic [29:0] i_vertex_c,
    input  logic [29:0] i_vertex_d,
    input  logic [31:0] i_conductivity,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [47:0] o_k_00,
    output logic signed [47:0] o_k_01,
    output logic signed [47:0] o_k_02,
    output logic signed [47:0] o_k_03,
    output logic signed [47:0] o_k_11,
    output logic signed [47:0] o_k_12,
    output logic signed [47:0] o_k_13,
    output logic signed [47:0] o_k_22,
    output logic signed [47:0] o_k_23,
    output logic signed [47:0] o_k_33,
    output logic        o_degenerate
);
    import tes_pkg::*;

    logic        r_step;
    logic [StepW-1:0] r_step_size;
    logic        w_en;
    t_vert       w_vert [4];
    logic        w_gv;
    t_prod_arr   w_prod;
    t_det        w_det;
    t_cs         w_cs;
    logic        w_sv;
    t_num_arr    w_num;
    t_den        w_den;
    t_flags      w_neg;
    logic        w_deg;
    logic        w_dv;
    t_quo_arr    w_quo;
    t_div_flags  w_fl;
    logic        r_out_v;
    t_out_arr    r_k;
    logic        r_deg;

    // Hold the step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size <= StepReset;
        end else if (i_step_size_we) begin
            r_step_size <= i_step_size;
        end
    end

    // Flag a zero step once per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 1'b0;
        end else begin
            r_step <= (r_step_size == '0);
        end
    end

    // Advance the whole pipeline unless the output is held
    assign w_en    = !r_out_v || i_ready;
    assign o_ready = w_en;

    assign w_vert[0] = i_vertex_a;
    assign w_vert[1] = i_vertex_b;
    assign w_vert[2] = i_vertex_c;
    assign w_vert[3] = i_vertex_d;

    tes_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_vert  (w_vert),
        .i_cond  (i_conductivity),
        .i_step  (r_step_size),
        .o_valid (w_gv),
        .o_prod  (w_prod),
        .o_det   (w_det),
        .o_cs    (w_cs)
    );

    tes_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_gv),
        .i_prod      (w_prod),
        .i_det       (w_det),
        .i_cs        (w_cs),
        .i_step_zero (r_step),
        .o_valid     (w_sv),
        .o_num       (w_num),
        .o_den       (w_den),
        .o_neg       (w_neg),
        .o_deg       (w_deg)
    );

    tes_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sv),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_neg   (w_neg),
        .i_deg   (w_deg),
        .o_valid (w_dv),
        .o_quo   (w_quo),
        .o_flags (w_fl)
    );

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_dv;
        end
    end

    // Apply sign, saturate, force zero on a degenerate element
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int n = 0; n < NEnt; n++) begin
                if (w_fl.deg) begin
                    r_k[n] <= '0;
                end else if (!w_fl.neg[n]) begin
                    r_k[n] <= w_fl.ovf[n] ? PosMax : {1'b0, w_quo[n]};
                end else begin
                    r_k[n] <= w_fl.ovf[n] ? NegMin : OutW'(-{1'b0, w_quo[n]});
                end
            end
            r_deg <= w_fl.deg;
        end
    end

    assign o_valid      = r_out_v;
    assign o_k_00       = r_k[0];
    assign o_k_01       = r_k[1];
    assign o_k_02       = r_k[2];
    assign o_k_03       = r_k[3];
    assign o_k_11       = r_k[4];
    assign o_k_12       = r_k[5];
    assign o_k_13       = r_k[6];
    assign o_k_22       = r_k[7];
    assign o_k_23       = r_k[8];
    assign o_k_33       = r_k[9];
    assign o_degenerate = r_deg;

endmodule

FILE: verif/tet_element_stiffness_chk.sv
`timescale 1ns / 1ps

module tet_element_stiffness_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step_size_we,
    input  logic [31:0] i_step_size,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [29:0] i_vertex_a,
    input  logic [29:0] i_vertex_b,
    input  logic [29:0] i_vertex_c,
    input  logic [29:0] i_vertex_d,
    input  logic [31:0] i_conductivity,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [47:0] o_k_00,
    input  logic [47:0] o_k_01,
    input  logic [47:0] o_k_02,
    input  logic [47:0] o_k_03,
    input  logic [47:0] o_k_11,
    input  logic [47:0] o_k_12,
    input  logic [47:0] o_k_13,
    input  logic [47:0] o_k_22,
    input  logic [47:0] o_k_23,
    input  logic [47:0] o_k_33,
    input  logic        o_degenerate,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked,
    output int          o_degen_seen
);
    import tes_pkg::*;

    typedef struct {
        logic [OutW-1:0] k [NEnt];
        logic            deg;
    } t_matrix;

    t_matrix       matrix_q [$];
    logic [31:0]   step_cur;

    // Exact stiffness of one element: c * s * (gi . gj) / (6 * det), rounded and saturated
    function automatic t_matrix element_stiffness(input logic [29:0] va, input logic [29:0] vb,
                                                  input logic [29:0] vc, input logic [29:0] vd,
                                                  input logic [31:0] cond,
                                                  input logic [31:0] step);
        t_matrix     m;
        logic [29:0] vt [4];
        longint      p [4][3];
        longint      e [3][3];
        longint      g [4][3];
        longint      det, dotp;
        logic [127:0] num, den, q;
        logic [47:0] kv;
        int          n, ai, bi;
        vt[0] = va; vt[1] = vb; vt[2] = vc; vt[3] = vd;
        for (int v = 0; v < 4; v++)
            for (int k = 0; k < 3; k++)
                p[v][k] = longint'((vt[v] >> (CoordBits * k)) & ((1 << CoordBits) - 1));
        for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
                e[r][k] = p[r + 1][k] - p[0][k];
        // gradients: g1 = e2 x e3, g2 = e3 x e1, g3 = e1 x e2
        for (int r = 0; r < 3; r++) begin
            ai = (r + 1) % 3;
            bi = (r + 2) % 3;
            for (int k = 0; k < 3; k++)
                g[r + 1][k] = e[ai][(k + 1) % 3] * e[bi][(k + 2) % 3]
                            - e[ai][(k + 2) % 3] * e[bi][(k + 1) % 3];
        end
        for (int k = 0; k < 3; k++)
            g[0][k] = -(g[1][k] + g[2][k] + g[3][k]);
        det = e[0][0] * g[1][0] + e[0][1] * g[1][1] + e[0][2] * g[1][2];
        m.deg = (det == 0) || (step == 0);
        n = 0;
        for (int i = 0; i < 4; i++) begin
            for (int j = i; j < 4; j++) begin
                kv = '0;
                if (!m.deg) begin
                    dotp = g[i][0] * g[j][0] + g[i][1] * g[j][1] + g[i][2] * g[j][2];
                    num = 128'(dotp < 0 ? -dotp : dotp);
                    num = num * 128'(cond);
                    num = num * 128'(step);
                    den = 128'(det < 0 ? -det : det) * 128'd1536;
                    q = (num + den / 2) / den;
                    // positive when dot and volume share a sign
                    if (q == 0)
                        kv = '0;
                    else if ((dotp < 0) == (det < 0))
                        kv = (q > 128'(PosMax)) ? PosMax : q[47:0];
                    else begin
                        if (q > (128'd1 << 47))
                            q = 128'd1 << 47;
                        kv = -q[47:0];
                    end
                end
                m.k[n] = kv;
                n++;
            end
        end
        return m;
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_checked = 0;
        o_degen_seen = 0;
    end

    // Track the step register, predict on each request, compare each result
    always @(posedge i_clk) begin
        logic [47:0] got [NEnt];
        t_matrix     want;
        if (!i_rst_n) begin
            step_cur <= StepReset;
        end else begin
            if (i_step_size_we)
                step_cur <= i_step_size;
            if (i_valid && o_ready)
                matrix_q.push_back(element_stiffness(i_vertex_a, i_vertex_b, i_vertex_c,
                                                     i_vertex_d, i_conductivity, step_cur));
            if (o_valid && i_ready) begin
                if (matrix_q.size() == 0) begin
                    report_mismatch("unexpected result", 48'(o_degenerate), 48'd0);
                end else begin
                    want = matrix_q.pop_front();
                    got = '{o_k_00, o_k_01, o_k_02, o_k_03, o_k_11,
                            o_k_12, o_k_13, o_k_22, o_k_23, o_k_33};
                    for (int n = 0; n < NEnt; n++)
                        if (got[n] !== want.k[n])
                            report_mismatch($sformatf("k[%0d]", n), got[n], want.k[n]);
                    if (o_degenerate !== want.deg)
                        report_mismatch("degenerate", 48'(o_degenerate), 48'(want.deg));
                    o_checked++;
                    if (want.deg)
                        o_degen_seen++;
                end
            end
        end
        o_pending = matrix_q.size();
    end

endmodule

FILE: verif/tet_element_stiffness_tb.sv
`timescale 1ns / 1ps

module tet_element_stiffness_tb;
    import tes_pkg::*;

    localparam int StallLimit = 5000;
    localparam int HoldCycles = 400;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_step_size_we = 0;
    logic [31:0] i_step_size = '0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [29:0] i_vertex_a = '0, i_vertex_b = '0, i_vertex_c = '0, i_vertex_d = '0;
    logic [31:0] i_conductivity = '0;
    logic        o_valid;
    logic        i_ready = 0;
    logic signed [47:0] o_k_00, o_k_01, o_k_02, o_k_03, o_k_11;
    logic signed [47:0] o_k_12, o_k_13, o_k_22, o_k_23, o_k_33;
    logic        o_degenerate;
    int          errors, pending, checked, degen_seen;
    int          sent = 0;
    int          idle_cycles = 0;
    bit          quiet = 0;
    bit          hold_req = 0;

    always #6 i_clk = ~i_clk;

    tet_element_stiffness i_dut (.*);

    tet_element_stiffness_chk i_chk (
        .*,
        .o_errors(errors),
        .o_pending(pending),
        .o_checked(checked),
        .o_degen_seen(degen_seen)
    );

    function automatic logic [29:0] grid_point(input int x, input int y, input int z);
        return {10'(z), 10'(y), 10'(x)};
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_element(input logic [29:0] a, input logic [29:0] b,
                                input logic [29:0] c, input logic [29:0] d,
                                input logic [31:0] cond);
        i_valid <= 1;
        i_vertex_a <= a;
        i_vertex_b <= b;
        i_vertex_c <= c;
        i_vertex_d <= d;
        i_conductivity <= cond;
        do @(posedge i_clk); while (!o_ready);
        sent++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Drain, let the pipeline settle, then write the step register
    task automatic write_step(input logic [31:0] value);
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        i_step_size_we <= 1;
        i_step_size <= value;
        @(posedge i_clk);
        i_step_size_we <= 0;
    endtask

    task automatic send_random_element();
        logic [29:0] a, b, c, d;
        logic [31:0] cond;
        int          sel, ax, ay, az;
        sel = $urandom_range(0, 99);
        ax = $urandom_range(0, 1023);
        ay = $urandom_range(0, 1023);
        az = $urandom_range(0, 1023);
        a = grid_point(ax, ay, az);
        if (sel < 50) begin
            a = 30'($urandom); b = 30'($urandom); c = 30'($urandom); d = 30'($urandom);
        end else if (sel < 80) begin
            // small element near a
            b = grid_point(ax + $urandom_range(0, 3), ay + $urandom_range(0, 3), az);
            c = grid_point(ax, ay + $urandom_range(0, 3), az + $urandom_range(0, 3));
            d = grid_point(ax + $urandom_range(0, 3), ay, az + $urandom_range(0, 3));
        end else if (sel < 90) begin
            // flat element: shared z plane or repeated vertex
            b = grid_point($urandom_range(0, 1023), $urandom_range(0, 1023), az);
            c = grid_point($urandom_range(0, 1023), $urandom_range(0, 1023), az);
            d = $urandom_range(0, 1) ? b : grid_point($urandom_range(0, 1023),
                                                      $urandom_range(0, 1023), az);
        end else begin
            a = $urandom_range(0, 1) ? '0 : '1;
            b = $urandom_range(0, 1) ? grid_point(1023, 0, 0) : 30'($urandom);
            c = grid_point(0, 1023, 0);
            d = $urandom_range(0, 1) ? grid_point(0, 0, 1023) : '1;
        end
        case ($urandom_range(0, 9))
            0:       cond = '0;
            1:       cond = '1;
            2:       cond = $urandom_range(0, 255);
            default: cond = $urandom;
        endcase
        send_element(a, b, c, d, cond);
    endtask

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        bit held;
        held = 0;
        @(posedge i_rst_n);
        i_ready <= 1;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1;
                i_ready <= 0;
                repeat (HoldCycles) @(posedge i_clk);
                i_ready <= 1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_ready <= 0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_ready <= 1;
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [31:0] steps [7];
        steps = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0, 32'h1,
                  32'h0000_8000, 32'h0003_0000, 32'h0};
        steps[6] = $urandom;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed elements at reset step
        send_element(grid_point(0, 0, 0), grid_point(1, 0, 0), grid_point(0, 1, 0),
                     grid_point(0, 0, 1), 32'h0001_0000);
        send_element(grid_point(0, 0, 0), grid_point(0, 1, 0), grid_point(1, 0, 0),
                     grid_point(0, 0, 1), 32'h0001_0000);
        send_element('0, '0, '0, '0, 32'h0001_0000);
        send_element('1, '1, '1, '1, '1);
        send_element('0, grid_point(1023, 0, 0), grid_point(0, 1023, 0),
                     grid_point(0, 0, 1023), '1);
        send_element('1, grid_point(0, 1023, 1023), grid_point(1023, 0, 1023),
                     grid_point(1023, 1023, 0), '1);
        send_element(grid_point(0, 0, 0), grid_point(1023, 0, 0), grid_point(0, 1023, 0),
                     grid_point(0, 0, 1023), 32'h0000_0001);
        send_element(grid_point(5, 5, 5), grid_point(6, 5, 5), grid_point(5, 6, 5),
                     grid_point(5, 5, 6), '0);
        send_element(grid_point(0, 0, 3), grid_point(9, 0, 3), grid_point(0, 9, 3),
                     grid_point(4, 4, 3), 32'h0002_0000);
        send_element(grid_point(2, 2, 2), grid_point(2, 2, 2), grid_point(7, 1, 0),
                     grid_point(1, 8, 9), 32'h0001_0000);
        send_element(grid_point(0, 0, 0), grid_point(1, 2, 3), grid_point(2, 4, 6),
                     grid_point(5, 1, 1), 32'h0001_0000);
        send_element(grid_point(512, 512, 512), grid_point(513, 512, 512),
                     grid_point(512, 1023, 512), grid_point(512, 512, 513), 32'hFFFF_FFFF);
        send_element(30'h2AAA_AAAA, 30'h1555_5555, 30'h3333_3333, 30'h0CCC_CCCC,
                     32'hAAAA_5555);

        for (int ph = 0; ph < 7; ph++) begin
            if (ph > 0)
                write_step(steps[ph]);
            hold_req = (ph == 1);
            quiet = (ph == 6);
            for (int n = 0; n < 190; n++)
                send_random_element();
        end

        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("Checked %0d of %0d elements over 7 step settings, %0d degenerate.",
                 checked, sent, degen_seen);
        if (errors == 0 && checked == sent)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
